@@ hdl/sobel_edge_magnitude_defines.svh @@
// =============================================================================
// Sobel edge magnitude: assertion macros
// Shared assertion forms for the checker of the edge detector.
// =============================================================================
`ifndef SOBEL_EDGE_MAGNITUDE_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_DEFINES_SVH

// Next-cycle implication, disabled while reset is asserted.
`define SEM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sobel_edge_magnitude: assertion failed");

// Next-cycle implication that is also checked while reset is asserted.
`define SEM_ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("sobel_edge_magnitude: assertion failed");

`endif

@@ hdl/sem_pkg.sv @@
// =============================================================================
// Sobel edge magnitude: package
// Constants, controller/datapath interface types and a helper function.
// =============================================================================
`default_nettype none

package sem_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam int PIX_W     = 8;
    localparam int COL_W     = 11;
    localparam int ROW_W     = 11;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;
    localparam int MIN_DIM      = 3;

    localparam int GRAD_W = 11;
    localparam int SQ_W   = 21;
    localparam int ROOT_W = 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic shift;
        logic sum;
        logic sq_x;
        logic sq_y;
        logic root_step;
        logic emit_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit_any;
        logic need_mag;
        logic root_last;
        logic slot_last;
        logic out_free;
    } t_status;

    // Saturates a programmed dimension to the supported range.
    function automatic int eff_dim(input logic [CFG_W-1:0] v, input int maxv);
        int val;
        val = int'(v);
        if (val < MIN_DIM) begin
            return MIN_DIM;
        end
        if (val > maxv) begin
            return maxv;
        end
        return val;
    endfunction

endpackage

`default_nettype wire

@@ hdl/sem_ram.sv @@
// =============================================================================
// Sobel edge magnitude: generic RAM
// One write port and one read port with registered read data.
// =============================================================================
`default_nettype none

module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hdl/sem_ctrl.sv @@
// =============================================================================
// Sobel edge magnitude: controller
// Sequences one pixel through read, gradient, square root and result beats.
// =============================================================================
`default_nettype none

module sem_ctrl
    import sem_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_SUM  = 7'b0000100,
        S_SQX  = 7'b0001000,
        S_SQY  = 7'b0010000,
        S_ROOT = 7'b0100000,
        S_EMIT = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                o_cmd.shift = 1'b1;
                priority if (!i_status.emit_any) begin
                    n_state = S_IDLE;
                end else if (i_status.need_mag) begin
                    n_state = S_SUM;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_SQX;
            end
            S_SQX: begin
                o_cmd.sq_x = 1'b1;
                n_state    = S_SQY;
            end
            S_SQY: begin
                o_cmd.sq_y = 1'b1;
                n_state    = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_status.root_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (i_status.slot_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

@@ hdl/sem_datapath.sv @@
// =============================================================================
// Sobel edge magnitude: datapath
// Line stores, 3x3 window, counters, gradient, square root and result register.
// =============================================================================
`default_nettype none

module sem_datapath
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic [PIX_W-1:0]     i_pixel,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [COL_W-1:0]          o_out_col,
    output logic [ROW_W-1:0]          o_out_row,
    output logic [PIX_W-1:0]          o_edge_res,
    output logic                      o_last_of_run
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    // Configuration, held as saturated dimensions.
    logic [WW-1:0] r_w_eff;
    logic [HW-1:0] r_h_eff;

    // Frame position of the next pixel.
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW:0]   x_inc;
    logic [RW:0]   y_inc;
    logic          wrap_x;
    logic          wrap_y;

    // Pixel in work and its position.
    logic [PIX_W-1:0] r_pix;
    logic [CW-1:0]    r_x;
    logic [RW-1:0]    r_y;

    logic [PIX_W-1:0] a_rdata;
    logic [PIX_W-1:0] b_rdata;

    logic [PIX_W-1:0] r_win [3][3];

    logic [GRAD_W-2:0]        gx_p, gx_n, gy_p, gy_n;
    logic signed [GRAD_W-1:0] r_gx, r_gy;
    logic signed [GRAD_W-1:0] sq_op;
    logic signed [2*GRAD_W-1:0] sq_prod;
    logic [SQ_W-1:0]          r_sq;

    logic [ROOT_W-1:0]   r_root;
    logic [ROOT_W-1:0]   r_mask;
    logic [ROOT_W-1:0]   root_try;
    logic [2*ROOT_W-1:0] root_try_sq;
    logic                sq_big;

    logic r_grp;
    logic r_sub;

    logic x_zero, x_ge2, x_last, y_ge1, y_ge2, y_last;
    logic slot_last;
    logic out_free;

    logic [CW-1:0]     sel_col;
    logic [RW-1:0]     sel_row;
    logic [PIX_W-1:0]  sel_val;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_eff <= WW'(eff_dim(CFG_W'(RESET_WIDTH), MAX_WIDTH));
            r_h_eff <= HW'(eff_dim(CFG_W'(RESET_HEIGHT), MAX_HEIGHT));
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_WIDTH) begin
                r_w_eff <= WW'(eff_dim(i_cfg_data, MAX_WIDTH));
            end
            if (i_cfg_index == REG_HEIGHT) begin
                r_h_eff <= HW'(eff_dim(i_cfg_data, MAX_HEIGHT));
            end
        end
    end

    // -------------------------------------------------------------- counters
    assign x_inc  = {1'b0, r_col} + (CW + 1)'(1);
    assign y_inc  = {1'b0, r_row} + (RW + 1)'(1);
    assign wrap_x = (x_inc >= (CW + 1)'(r_w_eff));
    assign wrap_y = (y_inc >= (RW + 1)'(r_h_eff));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cfg_valid &&
                     (i_cfg_index == REG_WIDTH || i_cfg_index == REG_HEIGHT)) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.accept) begin
            if (wrap_x) begin
                r_col <= '0;
                r_row <= wrap_y ? '0 : y_inc[RW-1:0];
            end else begin
                r_col <= x_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix <= i_pixel;
            r_x   <= r_col;
            r_y   <= r_row;
        end
    end

    // ----------------------------------------------------------- line stores
    // Read data is registered and arrives in the cycle after accept, when the write-back also takes place.
    sem_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .i_clk   (i_clk),
        .i_we    (i_cmd.shift),
        .i_waddr (r_x),
        .i_wdata (r_pix),
        .i_raddr (r_col),
        .o_rdata (a_rdata)
    );

    sem_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .i_clk   (i_clk),
        .i_we    (i_cmd.shift),
        .i_waddr (r_x),
        .i_wdata (a_rdata),
        .i_raddr (r_col),
        .o_rdata (b_rdata)
    );

    // ---------------------------------------------------------------- window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (i_cmd.shift) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= b_rdata;
            r_win[1][2] <= a_rdata;
            r_win[2][2] <= r_pix;
        end
    end

    // -------------------------------------------------------------- gradient
    assign gx_p = {2'b00, r_win[0][2]} + {1'b0, r_win[1][2], 1'b0} + {2'b00, r_win[2][2]};
    assign gx_n = {2'b00, r_win[0][0]} + {1'b0, r_win[1][0], 1'b0} + {2'b00, r_win[2][0]};
    assign gy_p = {2'b00, r_win[2][0]} + {1'b0, r_win[2][1], 1'b0} + {2'b00, r_win[2][2]};
    assign gy_n = {2'b00, r_win[0][0]} + {1'b0, r_win[0][1], 1'b0} + {2'b00, r_win[0][2]};

    // One shared multiplier squares Gx, then Gy.
    assign sq_op   = i_cmd.sq_x ? r_gx : r_gy;
    assign sq_prod = sq_op * sq_op;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_gx <= $signed({1'b0, gx_p}) - $signed({1'b0, gx_n});
            r_gy <= $signed({1'b0, gy_p}) - $signed({1'b0, gy_n});
        end
        if (i_cmd.sq_x) begin
            r_sq <= sq_prod[SQ_W-1:0];
        end else if (i_cmd.sq_y) begin
            r_sq <= r_sq + sq_prod[SQ_W-1:0];
        end
    end

    // ----------------------------------------------------------- square root
    // One result bit per cycle, most significant first; sums of 2^16 or more
    // saturate at once.
    assign root_try    = r_root | r_mask;
    assign root_try_sq = {ROOT_W'(0), root_try} * {ROOT_W'(0), root_try};
    assign sq_big      = (r_sq[SQ_W-1:2*ROOT_W] != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_y) begin
            r_root <= '0;
            r_mask <= {1'b1, {(ROOT_W - 1){1'b0}}};
        end else if (i_cmd.root_step) begin
            if (sq_big) begin
                r_root <= '1;
                r_mask <= '0;
            end else begin
                if (root_try_sq <= r_sq[2*ROOT_W-1:0]) begin
                    r_root <= root_try;
                end
                r_mask <= r_mask >> 1;
            end
        end
    end

    // ---------------------------------------------------------- result slots
    assign x_zero = (r_x == '0);
    assign x_ge2  = (r_x >= CW'(2));
    assign x_last = (({1'b0, r_x} + (CW + 1)'(1)) == (CW + 1)'(r_w_eff));
    assign y_ge1  = (r_y != '0);
    assign y_ge2  = (r_y >= RW'(2));
    assign y_last = (({1'b0, r_y} + (RW + 1)'(1)) == (RW + 1)'(r_h_eff));

    // Slot group 0 is the column left of the pixel (or column 0), group 1 the
    // right border column; sub 1 is the bottom border row paired with it.
    assign slot_last = !(!r_sub && y_last) && !(!r_grp && x_last);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_grp <= 1'b0;
            r_sub <= 1'b0;
        end else if (i_cmd.emit_load) begin
            if (!r_sub && y_last) begin
                r_sub <= 1'b1;
            end else begin
                r_grp <= 1'b1;
                r_sub <= 1'b0;
            end
        end
    end

    assign sel_col = r_grp ? r_x : (x_zero ? '0 : r_x - CW'(1));
    assign sel_row = r_sub ? r_y : r_y - RW'(1);
    assign sel_val = (!r_grp && !r_sub && x_ge2 && y_ge2) ? r_root : '0;

    // -------------------------------------------------------- output register
    assign out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            o_out_col     <= COL_W'(sel_col);
            o_out_row     <= ROW_W'(sel_row);
            o_edge_res    <= sel_val;
            o_last_of_run <= slot_last;
        end
    end

    assign o_status.emit_any  = y_ge1 && (x_zero || x_ge2);
    assign o_status.need_mag  = x_ge2 && y_ge2;
    assign o_status.root_last = sq_big || (r_mask == ROOT_W'(1));
    assign o_status.slot_last = slot_last;
    assign o_status.out_free  = out_free;

endmodule

`default_nettype wire

@@ hdl/sobel_edge_magnitude.sv @@
// =============================================================================
// Sobel edge magnitude
// Streaming 3x3 Sobel edge detector with clamped integer gradient magnitude.
// =============================================================================
//
//   Channel   Direction  Handshake                   Payload
//   in        input      i_in_valid / o_in_ready     i_pixel
//   out       output     o_out_valid / i_out_ready   o_out_col, o_out_row,
//                                                    o_edge_res, o_last_of_run
//   cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// A pixel that causes no result is accepted and read; a border pixel then sends
// its result beats; an interior pixel first sums Gx and Gy, squares them and takes
// 8 square-root steps, cut to 1 when the sum of squares reaches 2^16.
// Result beats stall while the output register is held by the consumer.
// Reset is synchronous; the line stores need no clearing pass.
//
`default_nettype none

module sobel_edge_magnitude
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [PIX_W-1:0]     i_pixel,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [COL_W-1:0]          o_out_col,
    output logic [ROW_W-1:0]          o_out_row,
    output logic [PIX_W-1:0]          o_edge_res,
    output logic                      o_last_of_run
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    sem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sem_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pixel       (i_pixel),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_out_col     (o_out_col),
        .o_out_row     (o_out_row),
        .o_edge_res    (o_edge_res),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire

@@ hdl/sem_checker.sv @@
// =============================================================================
// Sobel edge magnitude: port checker
// Watches the top-level ports for handshake and sequencing slips.
// =============================================================================
`default_nettype none

`include "sobel_edge_magnitude_defines.svh"

module sem_checker
    import sem_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_ready,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [COL_W-1:0]     o_out_col,
    input wire logic [ROW_W-1:0]     o_out_row,
    input wire logic [PIX_W-1:0]     o_edge_res,
    input wire logic                 o_last_of_run
);

    logic [COL_W+ROW_W+PIX_W:0] out_payload;

    assign out_payload = {o_out_col, o_out_row, o_edge_res, o_last_of_run};

    // A stalled result beat keeps its payload.
    `SEM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(out_payload))

    // Each pixel is worked on alone: the input closes after a beat is taken.
    `SEM_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)

    // No result can appear in the cycle right after a pixel is taken.
    `SEM_ASSERT_NEXT(a_no_early_result, i_in_valid && o_in_ready && !o_out_valid, !o_out_valid)

    // Reset empties the output register and opens the input.
    `SEM_ASSERT_NEXT_ALWAYS(a_reset_state, !i_rst_n, !o_out_valid && o_in_ready)

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (.*);

`default_nettype wire
